>>> hw/rtl/wfa_pkg.sv
// Shared types, codes and helpers of the wide fixed-point ALU.
`default_nettype none
package wfa_pkg;

	localparam int WFA_WORD_W  = 64;
	localparam int WFA_WIDE_W  = 128;
	localparam int WFA_HALF_W  = 32;
	localparam int WFA_DIV_BITS = 4;

	typedef enum logic [2:0] {
		OP_MUL_SHIFT      = 3'd0,
		OP_DIV_SHIFT      = 3'd1,
		OP_MUL_ADD_SHIFT  = 3'd2,
		OP_MUL_ADD3_SHIFT = 3'd3,
		OP_MUL_DIV        = 3'd4
	} op_t;

	// Item state from the product stages onwards, through the divider.
	typedef struct packed {
		logic [WFA_WORD_W-1:0] mres;
		logic                  is_div;
		logic                  dz;
		logic                  qneg;
		logic [WFA_WIDE_W-1:0] num;
		logic [WFA_WORD_W-1:0] dvs;
		logic [WFA_WORD_W-1:0] rem;
		logic [WFA_WORD_W-1:0] quo;
	} div_pl_t;

	function automatic logic [WFA_WORD_W-1:0] mag64(input logic [WFA_WORD_W-1:0] x);
		return x[WFA_WORD_W-1] ? (~x + 64'd1) : x;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/wfa_if.sv
// Request and response channels of the wide fixed-point ALU.
`default_nettype none
interface wfa_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         opcode;
	logic signed [63:0] operand_a;
	logic signed [63:0] operand_b;
	logic signed [63:0] operand_c;
	logic signed [63:0] operand_d;
	logic signed [63:0] operand_e;
	logic signed [63:0] operand_f;
	logic [5:0]         shift_amount;
	modport source (output valid, opcode, operand_a, operand_b, operand_c, operand_d,
		operand_e, operand_f, shift_amount, input ready);
	modport sink (input valid, opcode, operand_a, operand_b, operand_c, operand_d,
		operand_e, operand_f, shift_amount, output ready);
endinterface

interface wfa_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] result;
	logic               divide_by_zero;
	modport source (output valid, result, divide_by_zero, input ready);
	modport sink (input valid, result, divide_by_zero, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/wfa_front.sv
// Magnitudes, partial products, product sums and shift; prepares the divider item.
`default_nettype none
module wfa_front
	import wfa_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic        in_valid,
	input  wire logic [2:0]  opcode,
	input  wire logic [63:0] a,
	input  wire logic [63:0] b,
	input  wire logic [63:0] c,
	input  wire logic [63:0] d,
	input  wire logic [63:0] e,
	input  wire logic [63:0] f,
	input  wire logic [5:0]  sh,
	output logic             out_valid,
	output div_pl_t          out_pl
);

	logic        v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	op_t         op_s1, op_s2, op_s3, op_s4;
	logic [5:0]  sh_s1, sh_s2, sh_s3, sh_s4, sh_s5;
	logic [5:0]  sgn_s1, sgn_s2, sgn_s3;
	logic [63:0] mag_s1 [6];
	logic [63:0] pp_s2 [3][4];
	logic [63:0] dvs_s2, dvs_s3;
	logic [127:0] numds_s2, numds_s3;
	logic [127:0] up_s3 [3];
	logic [127:0] sp_s4 [3];
	logic [127:0] sum_s5;
	logic         mul_s4;
	div_pl_t      pl_s4, pl_s5, pl_s6;

	// Valid bits advance with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2;
			v_s4 <= v_s3; v_s5 <= v_s4; v_s6 <= v_s5;
		end
	end

	// Stage 1: capture signs and magnitudes
	always_ff @(posedge clk) begin
		if (en) begin
			op_s1     <= op_t'(opcode);
			sh_s1     <= sh;
			sgn_s1    <= {f[63], e[63], d[63], c[63], b[63], a[63]};
			mag_s1[0] <= mag64(a);
			mag_s1[1] <= mag64(b);
			mag_s1[2] <= mag64(c);
			mag_s1[3] <= mag64(d);
			mag_s1[4] <= mag64(e);
			mag_s1[5] <= mag64(f);
		end
	end

	// Stage 2: 32x32 partial products, shifted dividend, divisor pick
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				pp_s2[k][0] <= {32'd0, mag_s1[2*k][31:0]}  * {32'd0, mag_s1[2*k+1][31:0]};
				pp_s2[k][1] <= {32'd0, mag_s1[2*k][31:0]}  * {32'd0, mag_s1[2*k+1][63:32]};
				pp_s2[k][2] <= {32'd0, mag_s1[2*k][63:32]} * {32'd0, mag_s1[2*k+1][31:0]};
				pp_s2[k][3] <= {32'd0, mag_s1[2*k][63:32]} * {32'd0, mag_s1[2*k+1][63:32]};
			end
			numds_s2 <= {64'd0, mag_s1[0]} << sh_s1;
			dvs_s2   <= (op_s1 == OP_DIV_SHIFT) ? mag_s1[1] : mag_s1[2];
			op_s2    <= op_s1;
			sh_s2    <= sh_s1;
			sgn_s2   <= sgn_s1;
		end
	end

	// Stage 3: assemble unsigned 128-bit products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				up_s3[k] <= {64'd0, pp_s2[k][0]} + {32'd0, pp_s2[k][1], 32'd0}
					+ {32'd0, pp_s2[k][2], 32'd0} + {pp_s2[k][3], 64'd0};
			end
			numds_s3 <= numds_s2;
			dvs_s3   <= dvs_s2;
			op_s3    <= op_s2;
			sh_s3    <= sh_s2;
			sgn_s3   <= sgn_s2;
		end
	end

	// Stage 4: reapply product signs, set up the division
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				sp_s4[k] <= (sgn_s3[2*k] ^ sgn_s3[2*k+1]) ? (~up_s3[k] + 128'd1) : up_s3[k];
			end
			op_s4        <= op_s3;
			sh_s4        <= sh_s3;
			pl_s4.mres   <= '0;
			pl_s4.is_div <= (op_s3 == OP_DIV_SHIFT) || (op_s3 == OP_MUL_DIV);
			pl_s4.dz     <= ((op_s3 == OP_DIV_SHIFT) || (op_s3 == OP_MUL_DIV)) && (dvs_s3 == '0);
			pl_s4.qneg   <= (op_s3 == OP_DIV_SHIFT) ? (sgn_s3[0] ^ sgn_s3[1])
				: (sgn_s3[0] ^ sgn_s3[1] ^ sgn_s3[2]);
			pl_s4.num    <= (op_s3 == OP_DIV_SHIFT) ? numds_s3 : up_s3[0];
			pl_s4.dvs    <= dvs_s3;
			pl_s4.rem    <= '0;
			pl_s4.quo    <= '0;
		end
	end

	// Stage 5: sum the products the operation names
	always_comb begin
		case (op_s4)
			OP_MUL_SHIFT, OP_MUL_ADD_SHIFT, OP_MUL_ADD3_SHIFT: mul_s4 = 1'b1;
			default: mul_s4 = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s5 <= mul_s4 ? (sp_s4[0]
				+ ((op_s4 == OP_MUL_ADD_SHIFT || op_s4 == OP_MUL_ADD3_SHIFT) ? sp_s4[1] : '0)
				+ ((op_s4 == OP_MUL_ADD3_SHIFT) ? sp_s4[2] : '0)) : '0;
			sh_s5  <= sh_s4;
			pl_s5  <= pl_s4;
		end
	end

	// Stage 6: shift right and keep the low word in front of the divider item
	always_ff @(posedge clk) begin
		if (en) begin
			pl_s6 <= {64'(sum_s5 >> sh_s5), pl_s5[$bits(div_pl_t)-WFA_WORD_W-1:0]};
		end
	end

	assign out_valid = v_s6;
	assign out_pl    = pl_s6;

endmodule
`default_nettype wire

>>> hw/rtl/wfa_div_stage.sv
// One registered stage of the restoring divider, STEPS quotient bits per stage (WFA_DIV_BITS, four, by default).
`default_nettype none
module wfa_div_stage
	import wfa_pkg::*;
#(
	parameter int STEPS = WFA_DIV_BITS
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    en,
	input  wire logic    in_valid,
	input  wire div_pl_t in_pl,
	output logic         out_valid,
	output div_pl_t      out_pl
);

	div_pl_t nxt;

	// Shift in a dividend bit, subtract when the divisor fits
	always_comb begin
		logic [64:0] r2;
		nxt = in_pl;
		for (int i = 0; i < STEPS; i++) begin
			r2      = {nxt.rem, nxt.num[127]};
			nxt.num = {nxt.num[126:0], 1'b0};
			if (r2 >= {1'b0, nxt.dvs}) begin
				r2      = r2 - {1'b0, nxt.dvs};
				nxt.quo = {nxt.quo[62:0], 1'b1};
			end else begin
				nxt.quo = {nxt.quo[62:0], 1'b0};
			end
			nxt.rem = r2[63:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_pl <= nxt;
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/wide_fixed_point_alu.sv
// Top level of the wide fixed-point ALU.
// Pipelined signed 64-bit fixed-point unit with exact 128-bit intermediates. It takes one
// item per cycle while the response side does not stall and gives one result per item,
// in order. Every item passes the restoring divider chain (four quotient bits per stage by
// default), so that all operations share one depth; six stages before it form the
// magnitudes, the 32x32 partial products, the 128-bit products and their sum and shift,
// and one output register follows. When the response side stalls the whole pipeline
// holds. A zero divisor gives result 0 with divide_by_zero.
`default_nettype none
module wide_fixed_point_alu
	import wfa_pkg::*;
#(
	parameter int DIV_BITS = WFA_DIV_BITS
) (
	input wire logic  clk,
	input wire logic  arst_n,
	wfa_req_if.sink   request,
	wfa_rsp_if.source response
);

	localparam int DIV_STAGES = WFA_WIDE_W / DIV_BITS;

	logic                en;
	logic [DIV_STAGES:0] dv;
	div_pl_t             dpl [DIV_STAGES+1];
	logic                out_v_q;
	logic [63:0]         res_q;
	logic                dz_q;

	// Hold everything while a result waits
	assign en            = !out_v_q || response.ready;
	assign request.ready = en;

	wfa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (request.valid),
		.opcode    (request.opcode),
		.a         (request.operand_a),
		.b         (request.operand_b),
		.c         (request.operand_c),
		.d         (request.operand_d),
		.e         (request.operand_e),
		.f         (request.operand_f),
		.sh        (request.shift_amount),
		.out_valid (dv[0]),
		.out_pl    (dpl[0])
	);

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		wfa_div_stage #(.STEPS(DIV_BITS)) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (dv[g]),
			.in_pl     (dpl[g]),
			.out_valid (dv[g+1]),
			.out_pl    (dpl[g+1])
		);
	end

	// Output register: pick quotient or product result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= dv[DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dz_q <= dpl[DIV_STAGES].dz;
			if (dpl[DIV_STAGES].dz) begin
				res_q <= '0;
			end else if (dpl[DIV_STAGES].is_div) begin
				res_q <= dpl[DIV_STAGES].qneg ? (~dpl[DIV_STAGES].quo + 64'd1)
					: dpl[DIV_STAGES].quo;
			end else begin
				res_q <= dpl[DIV_STAGES].mres;
			end
		end
	end

	assign response.valid          = out_v_q;
	assign response.result         = res_q;
	assign response.divide_by_zero = dz_q;

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		response.valid && response.divide_by_zero |-> response.result == '0)
		else $error("divide by zero with nonzero result");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(dv))
		else $error("pipeline moved during a stall");

	a_last_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		en && dv[DIV_STAGES] |=> out_v_q)
		else $error("item lost at the output register");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		request.valid && request.ready && response.valid |-> response.ready)
		else $error("item accepted while the output is stalled");

endmodule
`default_nettype wire
